[design/lpl_pkg.sv]
// Shared constants and types for the stereo lookahead peak limiter.
package lpl_pkg;

    // Default sizing of the block
    localparam int MAX_LOOKAHEAD = 4095;
    localparam int QUEUE_DEPTH   = 8192;
    localparam int SAMPLE_BITS   = 24;

    // Fixed field widths
    localparam int GAIN_W     = 17;
    localparam int CEIL_W     = 16;
    localparam int COEF_W     = 24;
    localparam int LEN_W      = 12;
    localparam int FIDX_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Unity gain in Q1.16
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

    // Register reset values
    localparam logic [CEIL_W-1:0] CEIL_RESET = 16'd64786;
    localparam logic [COEF_W-1:0] COEF_RESET = 24'd16770226;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 12'd240;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHD = 2'd2;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PB_CHK,
        ST_PB_CMP,
        ST_PUSH,
        ST_EX_CHK,
        ST_EX_CMP,
        ST_TGT,
        ST_DIV,
        ST_ENV,
        ST_REL,
        ST_DLY,
        ST_SCALE,
        ST_OUT
    } t_state;

endpackage

[design/lookahead_peak_limiter_stereo.sv]
// Top level of the stereo lookahead peak limiter.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | push / full          | i_left_in, i_right_in
//  result   | empty / pop          | o_left_out, o_right_out, o_gain_now
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A frame takes longer when the gain needs the divide than when it does not, and grows with
// each deque entry popped from the back and each entry expired at the head; without the
// divide these first fill the wait for the read position unit.
// The restoring divide sets most of it.
// After reset the delay line is cleared while full stays high.
// A four-beat queue lets the input side run ahead while the back end is busy.
// The back end holds a finished beat in its output register until it is popped.
module lookahead_peak_limiter_stereo #(
    parameter int MAX_LOOKAHEAD = lpl_pkg::MAX_LOOKAHEAD,
    parameter int QUEUE_DEPTH   = lpl_pkg::QUEUE_DEPTH,
    parameter int SAMPLE_BITS   = lpl_pkg::SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_BITS-1:0]  i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]  i_right_in,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [SAMPLE_BITS-1:0]  o_left_out,
    output logic signed [SAMPLE_BITS-1:0]  o_right_out,
    output logic [lpl_pkg::GAIN_W-1:0]     o_gain_now
);

    localparam int FWD = 3 * SAMPLE_BITS;

    logic           f_wr, q_full, q_empty, q_rd, clearing;
    logic [FWD-1:0] f_word, q_word;

    assign full = q_full | clearing;

    lpl_front #(.SW(SAMPLE_BITS)) u_front (
        .i_push     (push),
        .i_full     (full),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .o_wr       (f_wr),
        .o_word     (f_word)
    );

    lpl_fifo #(.W(FWD)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_data  (f_word),
        .i_rd    (q_rd),
        .o_data  (q_word),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lpl_back #(
        .MAX_LOOKAHEAD (MAX_LOOKAHEAD),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .SW            (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_fifo_empty (q_empty),
        .i_fifo_data  (q_word),
        .o_fifo_pop   (q_rd),
        .o_clearing   (clearing),
        .empty        (empty),
        .pop          (pop),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_gain_now   (o_gain_now)
    );

endmodule

[design/lpl_front.sv]
// Front end: takes input beats, finds the frame peak and packs the queue word.
module lpl_front #(
    parameter int SW = lpl_pkg::SAMPLE_BITS
) (
    input  logic            i_push,
    input  logic            i_full,
    input  logic [SW-1:0]   i_left_in,
    input  logic [SW-1:0]   i_right_in,
    output logic            o_wr,
    output logic [3*SW-1:0] o_word
);

    logic signed [SW:0] l_ext, r_ext;
    logic        [SW:0] l_mag, r_mag;
    logic      [SW-1:0] peak;

    // Absolute values; the most negative sample still fits as a magnitude
    always_comb begin
        l_ext = {i_left_in[SW-1], i_left_in};
        r_ext = {i_right_in[SW-1], i_right_in};
        l_mag = l_ext[SW] ? (SW+1)'(-l_ext) : l_ext;
        r_mag = r_ext[SW] ? (SW+1)'(-r_ext) : r_ext;
        peak  = (l_mag > r_mag) ? l_mag[SW-1:0] : r_mag[SW-1:0];
    end

    // Pass the beat on when there is room
    assign o_wr   = i_push & ~i_full;
    assign o_word = {peak, i_left_in, i_right_in};

endmodule

[design/lpl_fifo.sv]
// Short queue that decouples the front end from the back end.
module lpl_fifo #(
    parameter int W = 3 * lpl_pkg::SAMPLE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PW = $clog2(lpl_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(lpl_pkg::FIFO_DEPTH + 1);

    logic [W-1:0]  r_mem [lpl_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(lpl_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;
    assign o_data  = r_mem[r_rp];

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PW'(lpl_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PW'(lpl_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[design/lpl_back.sv]
// Back end: sliding-max deque, gain divide, envelope, delay line and output stage.
module lpl_back #(
    parameter int MAX_LOOKAHEAD = lpl_pkg::MAX_LOOKAHEAD,
    parameter int QUEUE_DEPTH   = lpl_pkg::QUEUE_DEPTH,
    parameter int SW            = lpl_pkg::SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_fifo_empty,
    input  logic [3*SW-1:0]                i_fifo_data,
    output logic                           o_fifo_pop,
    output logic                           o_clearing,
    output logic                           empty,
    input  logic                           pop,
    output logic [SW-1:0]                  o_left_out,
    output logic [SW-1:0]                  o_right_out,
    output logic [lpl_pkg::GAIN_W-1:0]     o_gain_now
);

    localparam int DEPTH  = MAX_LOOKAHEAD + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int FW     = lpl_pkg::FIDX_W;
    localparam int GW     = lpl_pkg::GAIN_W;
    localparam int LW     = lpl_pkg::LEN_W;
    localparam int EW     = FW + SW;
    localparam int DW     = SW + 15;
    localparam int NUM_W  = AW + 1;
    localparam int MCW    = $clog2(NUM_W + 1);
    localparam int MR_W   = LW + 2;
    localparam int PW     = SW + GW + 1;
    localparam int AFW    = lpl_pkg::COEF_W + 1;
    localparam int RPW    = GW + AFW;

    // Configuration registers
    logic [lpl_pkg::CEIL_W-1:0] r_ceil;
    logic [lpl_pkg::COEF_W-1:0] r_coef;
    logic [LW-1:0]              r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil <= lpl_pkg::CEIL_RESET;
            r_coef <= lpl_pkg::COEF_RESET;
            r_len  <= lpl_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpl_pkg::CFG_CEILING: r_ceil <= i_cfg_data[lpl_pkg::CEIL_W-1:0];
                lpl_pkg::CFG_RELEASE: r_coef <= i_cfg_data[lpl_pkg::COEF_W-1:0];
                lpl_pkg::CFG_LOOKAHD: r_len  <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Effective lookahead: zero acts as one, clamp to MAX_LOOKAHEAD
    logic [LW-1:0] len_eff;
    always_comb begin
        if (r_len == '0) begin
            len_eff = LW'(1);
        end else if (32'(r_len) > 32'(MAX_LOOKAHEAD)) begin
            len_eff = LW'(MAX_LOOKAHEAD);
        end else begin
            len_eff = r_len;
        end
    end

    lpl_pkg::t_state r_state, n_state;

    // Per-frame working registers
    logic [SW-1:0]  r_l, r_r, r_peak, r_ahead;
    logic [FW-1:0]  r_fc;
    logic [QW-1:0]  r_head, r_tail;
    logic [GW-1:0]  r_env, r_tgt;
    logic [SW:0]    r_rem;
    logic [15:0]    r_quo, r_dlow;
    logic [4:0]     r_dcnt;
    logic [RPW-1:0] r_rprod;
    logic signed [PW-1:0] r_pl, r_pr;
    logic [AW-1:0]  r_wp, r_clr;
    logic           r_out_valid;
    logic [SW-1:0]  r_lo, r_ro;
    logic [GW-1:0]  r_go;

    // Ring pointer helpers
    function automatic logic [QW-1:0] q_next(input logic [QW-1:0] p);
        q_next = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction
    function automatic logic [QW-1:0] q_prev(input logic [QW-1:0] p);
        q_prev = (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // Deque memory: {frame index, peak}
    logic [EW-1:0] r_qmem [QUEUE_DEPTH];
    logic [EW-1:0] r_qrd;
    logic          q_we, q_re;
    logic [QW-1:0] q_raddr;

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[r_tail] <= {r_fc, r_peak};
        end
        if (q_re) begin
            r_qrd <= r_qmem[q_raddr];
        end
    end

    logic [SW-1:0] qrd_val;
    logic [FW-1:0] qrd_idx, age;
    assign qrd_val = r_qrd[SW-1:0];
    assign qrd_idx = r_qrd[EW-1:SW];
    assign age     = r_fc - qrd_idx;

    // Delay line memory, both channels per word
    logic [2*SW-1:0] r_dmem [DEPTH];
    logic [2*SW-1:0] r_drd;
    logic            d_we, d_re;
    logic [AW-1:0]   d_waddr, rd_pos;
    logic [2*SW-1:0] d_wdata;

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[d_waddr] <= d_wdata;
        end
        if (d_re) begin
            r_drd <= r_dmem[rd_pos];
        end
    end

    // Read position unit: (write_pos + 1) mod (len + 1), one bit a cycle
    logic [NUM_W-1:0] r_mnum;
    logic [MR_W-1:0]  r_mrem, m_try;
    logic [MCW-1:0]   r_mcnt;
    logic             r_mbusy, m_start;
    logic [MR_W-1:0]  m_div;

    assign m_div  = MR_W'(len_eff) + 1'b1;
    assign m_try  = {r_mrem[MR_W-2:0], r_mnum[NUM_W-1]};
    assign rd_pos = AW'(r_mrem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (m_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && r_mcnt == MCW'(NUM_W - 1)) begin
            r_mbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_start) begin
            r_mnum <= NUM_W'(r_wp) + 1'b1;
            r_mrem <= '0;
            r_mcnt <= '0;
        end else if (r_mbusy) begin
            r_mnum <= {r_mnum[NUM_W-2:0], 1'b0};
            r_mrem <= (m_try >= m_div) ? m_try - m_div : m_try;
            r_mcnt <= r_mcnt + 1'b1;
        end
    end

    // Target gain terms
    logic [DW-1:0]    ceil_q;
    logic             over;
    logic [SW:0]      d_try;
    assign ceil_q = {r_ceil, (SW-1)'(0)};
    assign over   = ({r_ahead, 16'd0} > (SW+16)'(ceil_q));
    assign d_try  = {r_rem[SW-1:0], r_dlow[15]};

    // Release step terms
    logic [GW-1:0]   rel_d;
    logic [AFW-1:0]  rel_a;
    logic [RPW:0]    rel_sum;
    assign rel_d   = r_tgt - r_env;
    assign rel_a   = AFW'(1 << lpl_pkg::COEF_W) - AFW'(r_coef);
    assign rel_sum = (RPW+1)'(r_rprod) + (RPW+1)'((1 << lpl_pkg::COEF_W) - 1);

    // Rounded scaled outputs
    logic signed [PW-1:0] rl, rr;
    assign rl = r_pl + PW'(32768);
    assign rr = r_pr + PW'(32768);

    logic can_load;
    assign can_load = ~r_out_valid | pop;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpl_pkg::ST_CLEAR:  if (r_clr == AW'(DEPTH - 1)) n_state = lpl_pkg::ST_IDLE;
            lpl_pkg::ST_IDLE:   if (!i_fifo_empty) n_state = lpl_pkg::ST_PB_CHK;
            lpl_pkg::ST_PB_CHK: n_state = (r_head == r_tail) ? lpl_pkg::ST_PUSH
                                                             : lpl_pkg::ST_PB_CMP;
            lpl_pkg::ST_PB_CMP: n_state = (qrd_val > r_peak) ? lpl_pkg::ST_PUSH
                                                             : lpl_pkg::ST_PB_CHK;
            lpl_pkg::ST_PUSH:   n_state = lpl_pkg::ST_EX_CHK;
            lpl_pkg::ST_EX_CHK: n_state = (r_head == r_tail) ? lpl_pkg::ST_TGT
                                                             : lpl_pkg::ST_EX_CMP;
            lpl_pkg::ST_EX_CMP: n_state = (age > FW'(len_eff)) ? lpl_pkg::ST_EX_CHK
                                                               : lpl_pkg::ST_TGT;
            lpl_pkg::ST_TGT:    n_state = over ? lpl_pkg::ST_DIV : lpl_pkg::ST_ENV;
            lpl_pkg::ST_DIV:    if (r_dcnt == 5'd15) n_state = lpl_pkg::ST_ENV;
            lpl_pkg::ST_ENV:    n_state = (r_tgt < r_env) ? lpl_pkg::ST_DLY
                                                          : lpl_pkg::ST_REL;
            lpl_pkg::ST_REL:    n_state = lpl_pkg::ST_DLY;
            lpl_pkg::ST_DLY:    if (!r_mbusy) n_state = lpl_pkg::ST_SCALE;
            lpl_pkg::ST_SCALE:  n_state = lpl_pkg::ST_OUT;
            lpl_pkg::ST_OUT:    if (can_load) n_state = lpl_pkg::ST_IDLE;
            default:            n_state = lpl_pkg::ST_CLEAR;
        endcase
    end

    // Sequencer strobes
    always_comb begin
        o_fifo_pop = 1'b0;
        m_start    = 1'b0;
        q_we       = 1'b0;
        q_re       = 1'b0;
        q_raddr    = r_head;
        d_we       = 1'b0;
        d_re       = 1'b0;
        d_waddr    = r_wp;
        d_wdata    = {r_l, r_r};
        o_clearing = 1'b0;
        unique case (r_state)
            lpl_pkg::ST_CLEAR: begin
                o_clearing = 1'b1;
                d_we       = 1'b1;
                d_waddr    = r_clr;
                d_wdata    = '0;
            end
            lpl_pkg::ST_IDLE: begin
                o_fifo_pop = ~i_fifo_empty;
                m_start    = ~i_fifo_empty;
            end
            lpl_pkg::ST_PB_CHK: begin
                q_re    = (r_head != r_tail);
                q_raddr = q_prev(r_tail);
            end
            lpl_pkg::ST_PUSH:   q_we = 1'b1;
            lpl_pkg::ST_EX_CHK: q_re = (r_head != r_tail);
            lpl_pkg::ST_DLY: begin
                d_we = ~r_mbusy;
                d_re = ~r_mbusy;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpl_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fc        <= '0;
            r_env       <= lpl_pkg::UNITY_GAIN;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lpl_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // Drop back entries that are not larger than the new peak
            if (r_state == lpl_pkg::ST_PB_CMP && !(qrd_val > r_peak)) begin
                r_tail <= q_prev(r_tail);
            end
            // Append; on a full ring drop the oldest
            if (r_state == lpl_pkg::ST_PUSH) begin
                r_tail <= q_next(r_tail);
                if (q_next(r_tail) == r_head) begin
                    r_head <= q_next(r_head);
                end
            end
            // Expire stale head entries
            if (r_state == lpl_pkg::ST_EX_CMP && age > FW'(len_eff)) begin
                r_head <= q_next(r_head);
            end
            if (r_state == lpl_pkg::ST_ENV && r_tgt < r_env) begin
                r_env <= r_tgt;
            end
            if (r_state == lpl_pkg::ST_REL) begin
                r_env <= r_env + rel_sum[RPW-2:lpl_pkg::COEF_W];
            end
            if (r_state == lpl_pkg::ST_OUT && can_load) begin
                r_out_valid <= 1'b1;
                r_wp        <= rd_pos;
                r_fc        <= r_fc + 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == lpl_pkg::ST_IDLE && !i_fifo_empty) begin
            r_peak <= i_fifo_data[3*SW-1:2*SW];
            r_l    <= i_fifo_data[2*SW-1:SW];
            r_r    <= i_fifo_data[SW-1:0];
        end
        if (r_state == lpl_pkg::ST_EX_CHK && r_head == r_tail) begin
            r_ahead <= '0;
        end
        if (r_state == lpl_pkg::ST_EX_CMP && !(age > FW'(len_eff))) begin
            r_ahead <= qrd_val;
        end
        // Set up the divide or take unity
        if (r_state == lpl_pkg::ST_TGT) begin
            r_rem  <= (SW+1)'(ceil_q[DW-1:16]);
            r_dlow <= ceil_q[15:0];
            r_dcnt <= '0;
            r_quo  <= '0;
            if (!over) begin
                r_tgt <= lpl_pkg::UNITY_GAIN;
            end
        end
        // Restoring divide, one quotient bit a cycle
        if (r_state == lpl_pkg::ST_DIV) begin
            r_dlow <= {r_dlow[14:0], 1'b0};
            r_dcnt <= r_dcnt + 1'b1;
            if (d_try >= {1'b0, r_ahead}) begin
                r_rem <= d_try - {1'b0, r_ahead};
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= d_try;
                r_quo <= {r_quo[14:0], 1'b0};
            end
            if (r_dcnt == 5'd15) begin
                r_tgt <= GW'({r_quo[14:0], (d_try >= {1'b0, r_ahead})});
            end
        end
        if (r_state == lpl_pkg::ST_ENV) begin
            r_rprod <= RPW'(rel_d) * RPW'(rel_a);
        end
        // Scale the delayed pair by the envelope
        if (r_state == lpl_pkg::ST_SCALE) begin
            r_pl <= PW'($signed(r_drd[2*SW-1:SW])) * $signed(PW'({1'b0, r_env}));
            r_pr <= PW'($signed(r_drd[SW-1:0]))    * $signed(PW'({1'b0, r_env}));
        end
        if (r_state == lpl_pkg::ST_OUT && can_load) begin
            r_lo <= rl[SW+15:16];
            r_ro <= rr[SW+15:16];
            r_go <= r_env;
        end
    end

    assign empty       = ~r_out_valid;
    assign o_left_out  = r_lo;
    assign o_right_out = r_ro;
    assign o_gain_now  = r_go;

endmodule

[design/lpl_checker.sv]
// Port-level checks for the limiter, bound to the top level.
module lpl_checker #(
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [SAMPLE_BITS-1:0]     o_left_out,
    input logic [lpl_pkg::GAIN_W-1:0] o_gain_now
);

    // Reset leaves no result and holds off input during the clearing pass
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input taken right after reset");

    // Envelope never exceeds unity
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_gain_now <= lpl_pkg::UNITY_GAIN))
        else $error("gain above unity");

    // A waiting beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_left_out) && $stable(o_gain_now)))
        else $error("waiting result changed");

endmodule

bind lookahead_peak_limiter_stereo lpl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lpl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_left_out (o_left_out),
    .o_gain_now (o_gain_now)
);
